// ===== rtl/iaws_pkg.sv =====
// Package for the IMU ADC window-sum block.
// Holds payload structs, channel and register codes, controller types and constants.
// No dependencies.
package iaws_pkg;

  localparam int NUM_CH         = 8;
  localparam int CH_W           = 3;
  localparam int SAMPLE_W       = 10;
  localparam int SUM_W          = 16;
  localparam int BATT_W         = 9;
  localparam int CFG_IDX_W      = 3;
  localparam int WINDOW_DEF     = 8;
  localparam int MID_VALUE      = 1023 / 2;
  localparam int BATT_MULT      = 82;
  localparam int BATT_SHIFT     = 7;

  localparam logic [CH_W-1:0] CH_ACC_Y = 3'd0;
  localparam logic [CH_W-1:0] CH_ACC_X = 3'd1;
  localparam logic [CH_W-1:0] CH_GYR_Z = 3'd2;
  localparam logic [CH_W-1:0] CH_GYR_X = 3'd3;
  localparam logic [CH_W-1:0] CH_GYR_Y = 3'd4;
  localparam logic [CH_W-1:0] CH_PRESS = 3'd5;
  localparam logic [CH_W-1:0] CH_BATT  = 3'd6;
  localparam logic [CH_W-1:0] CH_ACC_Z = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Z  = 3'd5;

  localparam logic KIND_STORE   = 1'b0;
  localparam logic KIND_PROCESS = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] accel_sum_x;
    logic signed [SUM_W-1:0] accel_sum_y;
    logic signed [SUM_W-1:0] accel_sum_z;
    logic signed [SUM_W-1:0] rate_sum_x;
    logic signed [SUM_W-1:0] rate_sum_y;
    logic signed [SUM_W-1:0] rate_sum_z;
    logic [SUM_W-1:0]        pressure_sum;
    logic [BATT_W-1:0]       battery_decivolts;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WR,
    S_SHIFT,
    S_MUL,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic clr_en;
    logic capture;
    logic rd_en;
    logic wr_en;
    logic shift_en;
    logic mul_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/iaws_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module iaws_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/iaws_ctrl.sv =====
// Controller for the IMU ADC window-sum block: clear pass, store and process sequencing.
// Depends on iaws_pkg.
module iaws_ctrl
  import iaws_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_kind == KIND_PROCESS) ? S_SHIFT : S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/iaws_dp.sv =====
// Datapath for the IMU ADC window-sum block: sample store, running sums,
// pointers, offset registers, battery scaling and the output register.
// Depends on iaws_pkg and iaws_ram.
module iaws_dp
  import iaws_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SUM_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  ctrl_cmd_t            cmd,
  output ctrl_sts_t            sts
);

  localparam int RW    = $clog2(WINDOW_SAMPLES);
  localparam int DEPTH = WINDOW_SAMPLES * NUM_CH;
  localparam int AW    = $clog2(DEPTH);
  localparam int P     = $clog2(WINDOW_SAMPLES + 1) - 1;
  localparam logic [SUM_W-1:0] GYRO_MID = SUM_W'(MID_VALUE * WINDOW_SAMPLES);

  logic [CH_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0] val_r;
  logic [RW-1:0]       ptr_r [NUM_CH];
  logic [SUM_W-1:0]    sum_r [NUM_CH];
  logic [AW-1:0]       clr_cnt_r;
  logic [SUM_W-1:0]    off_ax_r, off_ay_r, off_az_r, off_gx_r, off_gy_r, off_gz_r;
  logic [SUM_W-1:0]    b1_r, b1_nxt;
  logic [SUM_W-1:0]    prod_r, prod_nxt;
  logic                out_valid_r;
  out_item_t           out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [RW-1:0]       ptr_cur;
  logic [SUM_W:0]      b_rnd;
  logic [SUM_W:0]      p_rnd;

  assign ptr_cur   = ptr_r[ch_r];
  assign ram_raddr = {ptr_cur, ch_r};
  assign ram_we    = cmd.clr_en | cmd.wr_en;
  assign ram_waddr = cmd.clr_en ? clr_cnt_r : {ptr_cur, ch_r};
  assign ram_wdata = cmd.clr_en ? '0 : val_r;

  iaws_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r  <= in_data.channel;
      val_r <= in_data.sample_value;
    end
  end

  // running window sums; old sample leaves, new one enters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sum_r[i] <= '0;
        ptr_r[i] <= '0;
      end
    end else if (cmd.wr_en) begin
      sum_r[ch_r] <= sum_r[ch_r] + SUM_W'(val_r) - SUM_W'(ram_rdata);
      ptr_r[ch_r] <= (ptr_cur == RW'(WINDOW_SAMPLES - 1)) ? '0 : ptr_cur + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_ax_r <= '0;
      off_ay_r <= '0;
      off_az_r <= '0;
      off_gx_r <= SUM_W'(0) - GYRO_MID;
      off_gy_r <= SUM_W'(0) - GYRO_MID;
      off_gz_r <= GYRO_MID;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL_OFFSET_X: off_ax_r <= cfg_wdata;
        REG_ACCEL_OFFSET_Y: off_ay_r <= cfg_wdata;
        REG_ACCEL_OFFSET_Z: off_az_r <= cfg_wdata;
        REG_GYRO_OFFSET_X:  off_gx_r <= cfg_wdata;
        REG_GYRO_OFFSET_Y:  off_gy_r <= cfg_wdata;
        REG_GYRO_OFFSET_Z:  off_gz_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // battery: rounded shift by P+1, times 82, rounded shift by 7
  assign b_rnd    = {1'b0, sum_r[CH_BATT]} + (SUM_W+1)'(2 ** P);
  assign b1_nxt   = SUM_W'(b_rnd >> (P + 1));
  assign prod_nxt = SUM_W'(SUM_W'(BATT_MULT) * b1_r);
  assign p_rnd    = {1'b0, prod_r} + (SUM_W+1)'(2 ** (BATT_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      b1_r <= b1_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    out_nxt.accel_sum_x       = SUM_W'(0) - sum_r[CH_ACC_X] - off_ax_r;
    out_nxt.accel_sum_y       = SUM_W'(0) - sum_r[CH_ACC_Y] - off_ay_r;
    out_nxt.accel_sum_z       = SUM_W'(0) - sum_r[CH_ACC_Z] - off_az_r;
    out_nxt.rate_sum_x        = SUM_W'(0) - sum_r[CH_GYR_X] - off_gx_r;
    out_nxt.rate_sum_y        = SUM_W'(0) - sum_r[CH_GYR_Y] - off_gy_r;
    out_nxt.rate_sum_z        = sum_r[CH_GYR_Z] - off_gz_r;
    out_nxt.pressure_sum      = sum_r[CH_PRESS];
    out_nxt.battery_decivolts = p_rnd[BATT_SHIFT +: BATT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/imu_adc_window_sum_offset.sv =====
// Top level of the IMU ADC window-sum block: controller, datapath and checks.
// Depends on iaws_pkg, iaws_ctrl, iaws_dp (and through it iaws_ram).
//
// Keeps the last WINDOW_SAMPLES samples of eight ADC channels and a running
// sum per channel. After reset a clearing pass zeroes the sample store, one
// entry a cycle, all 8 * WINDOW_SAMPLES entries (64 at the default); requests
// are stalled until it ends. A store request then steps through capture,
// store read of the leaving sample, and write and sum update. A process
// request steps through capture, battery rounding shift, the multiply by 82
// and output load, which waits until the output register is free; the result
// register holds it while stores go on. Offsets may be written only when idle.
module imu_adc_window_sum_offset
  import iaws_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SUM_W-1:0]     cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  iaws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iaws_dp #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("requests taken during the clearing pass");

  a_store_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.kind == KIND_STORE && !out_valid) |=> !out_valid)
    else $error("store request produced a result");

  a_process_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.kind == KIND_PROCESS && !out_valid) |-> ##4 out_valid)
    else $error("process request result late");

endmodule
